>>> src/periodic_slot_scheduler_unit_assert.svh
// assertion macros for the periodic slot scheduler
// expects clk and rst in the scope of every use
`ifndef PERIODIC_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_SLOT_SCHEDULER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pss assertion failed");
`define PSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pss assertion failed");
`else
`define PSS_ASSERT_NOW(lbl, ante, cons)
`define PSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/pss_pkg.sv
// types and codes shared by the periodic slot scheduler
// no dependencies
package pss_pkg;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_TICK       = 2'd2,
    REQ_DONE       = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_REG_REPLY   = 3'd0,
    KIND_UNREG_REPLY = 3'd1,
    KIND_FIRE        = 3'd2,
    KIND_DONE_REPLY  = 3'd3,
    KIND_TICK_END    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_REPLY
  } state_t;

  // one slot of the table
  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] reload;
    logic [15:0] remaining;
    logic        irq;
    logic        busy;
  } entry_t;

  // ring step control from the sequencer to the cells
  typedef struct packed {
    logic   shift;
    entry_t tail;
  } ring_ctl_t;

endpackage

>>> src/periodic_slot_scheduler_unit.sv
// busy covers one full turn of the slot ring and the reply state; the final result is
// registered and shows once the sequencer is back in idle, where the next start can be
// taken, so a new request is accepted only after the last one is through.
// fire results come at most one per cycle during the turn, in slot order.
// synchronous reset clears every slot (all free) and returns the sequencer to idle.
// depends on pss_pkg, pss_cell, pss_ctrl and periodic_slot_scheduler_unit_assert.svh
`include "periodic_slot_scheduler_unit_assert.svh"
module periodic_slot_scheduler_unit
  import pss_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  task_id,
  input  logic [15:0] interval,
  input  logic        in_interrupt,
  input  logic [2:0]  done_slot,
  output logic        result_valid,
  output logic [2:0]  kind,
  output logic        ok,
  output logic [2:0]  slot,
  output logic [7:0]  fired_id,
  output logic        fired_in_interrupt,
  output logic        last
);

  entry_t    cells_q [SLOTS];
  ring_ctl_t ring;

  // ring: each cell takes its upper neighbor, the top takes the processed head
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    entry_t d;
    if (k == SLOTS - 1) begin : g_top
      assign d = ring.tail;
    end else begin : g_mid
      assign d = cells_q[k+1];
    end
    pss_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring.shift),
      .d     (d),
      .q     (cells_q[k])
    );
  end

  pss_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .req_type           (req_type),
    .task_id            (task_id),
    .interval           (interval),
    .in_interrupt       (in_interrupt),
    .done_slot          (done_slot),
    .head               (cells_q[0]),
    .ring               (ring),
    .busy               (busy),
    .result_valid       (result_valid),
    .kind               (kind),
    .ok                 (ok),
    .slot               (slot),
    .fired_id           (fired_id),
    .fired_in_interrupt (fired_in_interrupt),
    .last               (last)
  );

  `PSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `PSS_ASSERT_NOW(a_final_idle, result_valid && last, !busy)
  `PSS_ASSERT_NOW(a_fire_in_pass, result_valid && !last, busy && kind == KIND_FIRE)
  `PSS_ASSERT_NOW(a_no_shift_idle, !busy, !ring.shift)

endmodule

>>> src/pss_cell.sv
// one slot cell of the rotating table
// depends on pss_pkg
module pss_cell
  import pss_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

>>> src/pss_ctrl.sv
// sequencer: walks the slot ring once per request and builds the results
// depends on pss_pkg
module pss_ctrl
  import pss_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  logic [7:0] task_id,
  input  logic [15:0] interval,
  input  logic       in_interrupt,
  input  logic [2:0] done_slot,
  input  entry_t     head,
  output ring_ctl_t  ring,
  output logic       busy,
  output logic       result_valid,
  output logic [2:0] kind,
  output logic       ok,
  output logic [2:0] slot,
  output logic [7:0] fired_id,
  output logic       fired_in_interrupt,
  output logic       last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t          state, state_next;
  logic [IDX_W-1:0] step;
  req_t            req;
  logic [7:0]      id;
  logic [15:0]     ival;
  logic            irq;
  logic [2:0]      ds;
  logic            found;
  logic            rec_ok;
  logic [2:0]      rec_slot;
  logic [7:0]      rec_id;
  logic            rec_irq;

  logic [7:0] step_ext;
  logic       last_step;
  logic       hit;
  logic       fire;
  entry_t     tail;

  assign step_ext  = 8'(step);
  assign last_step = (step == IDX_W'(SLOTS - 1));
  assign busy      = (state != ST_IDLE);

  // processing of the slot at the head of the ring
  always_comb begin
    tail = head;
    hit  = 1'b0;
    fire = 1'b0;
    case (req)
      REQ_REGISTER: begin
        if (id != 8'd0 && !found && head.owner == 8'd0) begin
          hit            = 1'b1;
          tail.owner     = id;
          tail.reload    = ival - 16'd1;
          tail.remaining = ival;
          tail.irq       = irq;
          tail.busy      = 1'b0;
        end
      end
      REQ_UNREGISTER: begin
        if (id != 8'd0 && !found && head.owner == id) begin
          hit  = 1'b1;
          tail = '0;
        end
      end
      REQ_TICK: begin
        if (head.owner != 8'd0 && !head.busy) begin
          if (head.remaining == 16'd0) begin
            fire           = 1'b1;
            tail.remaining = head.reload;
            if (!head.irq) begin
              tail.busy = 1'b1;
            end
          end else begin
            tail.remaining = head.remaining - 16'd1;
          end
        end
      end
      REQ_DONE: begin
        if ({5'd0, ds} == step_ext) begin
          hit = 1'b1;
          if (head.owner != 8'd0 && head.busy) begin
            tail.busy = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign ring.shift = (state == ST_SWEEP);
  assign ring.tail  = tail;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_SWEEP;
      ST_SWEEP: if (last_step) state_next = ST_REPLY;
      ST_REPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and per-pass records
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == ST_IDLE && start) begin
      step     <= '0;
      req      <= req_t'(req_type);
      id       <= task_id;
      ival     <= interval;
      irq      <= in_interrupt;
      ds       <= done_slot;
      found    <= 1'b0;
      rec_ok   <= 1'b0;
      rec_slot <= 3'd0;
      rec_id   <= 8'd0;
      rec_irq  <= 1'b0;
    end else if (state == ST_SWEEP) begin
      step <= last_step ? '0 : step + IDX_W'(1);
      if (hit) begin
        found    <= 1'b1;
        rec_slot <= step_ext[2:0];
        rec_id   <= head.owner;
        rec_irq  <= (req == REQ_REGISTER) ? irq : head.irq;
        rec_ok   <= (req == REQ_DONE) ? (head.owner != 8'd0 && head.busy) : 1'b1;
      end
    end
  end

  // result register: one result per strobe, each fire result and the final reply
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_SWEEP && fire) || (state == ST_REPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SWEEP) begin
      kind               <= KIND_FIRE;
      ok                 <= 1'b1;
      slot               <= step_ext[2:0];
      fired_id           <= head.owner;
      fired_in_interrupt <= head.irq;
      last               <= 1'b0;
    end else begin
      last <= 1'b1;
      case (req)
        REQ_REGISTER, REQ_UNREGISTER: begin
          kind               <= (req == REQ_REGISTER) ? KIND_REG_REPLY : KIND_UNREG_REPLY;
          ok                 <= found;
          slot               <= found ? rec_slot : 3'd0;
          fired_id           <= id;
          fired_in_interrupt <= found ? rec_irq : 1'b0;
        end
        REQ_DONE: begin
          kind               <= KIND_DONE_REPLY;
          ok                 <= rec_ok;
          slot               <= ds;
          fired_id           <= rec_id;
          fired_in_interrupt <= rec_irq;
        end
        default: begin
          kind               <= KIND_TICK_END;
          ok                 <= 1'b1;
          slot               <= 3'd0;
          fired_id           <= 8'd0;
          fired_in_interrupt <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> bench/periodic_slot_scheduler_unit_tb.sv
// self-checking bench for periodic_slot_scheduler_unit: directed corner cases and
// weighted random traffic, checked against an in-bench model of the slot table
// depends on pss_pkg and the scheduler rtl
`timescale 1ns / 100ps
module periodic_slot_scheduler_unit_tb;
  import pss_pkg::*;

  localparam int SLOTS        = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 347;

  typedef struct packed {
    kind_t      kind;
    logic       ok;
    logic [2:0] slot;
    logic [7:0] id;
    logic       irq;
    logic       last;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [7:0]  task_id;
  logic [15:0] interval;
  logic        in_interrupt;
  logic [2:0]  done_slot;
  logic        result_valid;
  logic [2:0]  kind;
  logic        ok;
  logic [2:0]  slot;
  logic [7:0]  fired_id;
  logic        fired_in_interrupt;
  logic        last;

  // shadow copy of the slot table
  logic [7:0]  tbl_owner[SLOTS];
  logic [15:0] tbl_reload[SLOTS];
  logic [15:0] tbl_remaining[SLOTS];
  logic        tbl_irq[SLOTS];
  logic        tbl_busy[SLOTS];

  reply_t pending_replies[$];
  int     error_count = 0;
  int     cycle_count = 0;

  periodic_slot_scheduler_unit #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .task_id(task_id),
    .interval(interval),
    .in_interrupt(in_interrupt),
    .done_slot(done_slot),
    .result_valid(result_valid),
    .kind(kind),
    .ok(ok),
    .slot(slot),
    .fired_id(fired_id),
    .fired_in_interrupt(fired_in_interrupt),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_reply(kind_t k, logic r_ok, logic [2:0] s, logic [7:0] id,
                            logic irq, logic lst);
    reply_t r;
    r.kind = k;
    r.ok   = r_ok;
    r.slot = s;
    r.id   = id;
    r.irq  = irq;
    r.last = lst;
    pending_replies.push_back(r);
  endtask

  // updates the shadow table for one accepted transaction and queues its replies
  task automatic schedule_replies(req_t r, logic [7:0] id, logic [15:0] ival, logic irq,
                                  logic [2:0] ds);
    int   hit;
    logic done_ok;
    hit = -1;
    case (r)
      REQ_REGISTER: begin
        if (id != 8'd0)
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_owner[i] == 8'd0) hit = i;
        if (hit >= 0) begin
          tbl_owner[hit]     = id;
          tbl_reload[hit]    = ival - 16'd1;
          tbl_remaining[hit] = ival;
          tbl_irq[hit]       = irq;
          tbl_busy[hit]      = 1'b0;
          push_reply(KIND_REG_REPLY, 1'b1, 3'(hit), id, irq, 1'b1);
        end else begin
          push_reply(KIND_REG_REPLY, 1'b0, 3'd0, id, 1'b0, 1'b1);
        end
      end
      REQ_UNREGISTER: begin
        if (id != 8'd0)
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_owner[i] == id) hit = i;
        if (hit >= 0) begin
          push_reply(KIND_UNREG_REPLY, 1'b1, 3'(hit), id, tbl_irq[hit], 1'b1);
          tbl_owner[hit]     = 8'd0;
          tbl_reload[hit]    = 16'd0;
          tbl_remaining[hit] = 16'd0;
          tbl_irq[hit]       = 1'b0;
          tbl_busy[hit]      = 1'b0;
        end else begin
          push_reply(KIND_UNREG_REPLY, 1'b0, 3'd0, id, 1'b0, 1'b1);
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_owner[i] != 8'd0 && !tbl_busy[i]) begin
            if (tbl_remaining[i] == 16'd0) begin
              push_reply(KIND_FIRE, 1'b1, 3'(i), tbl_owner[i], tbl_irq[i], 1'b0);
              if (!tbl_irq[i]) tbl_busy[i] = 1'b1;
              tbl_remaining[i] = tbl_reload[i];
            end else begin
              tbl_remaining[i] = tbl_remaining[i] - 16'd1;
            end
          end
        end
        push_reply(KIND_TICK_END, 1'b1, 3'd0, 8'd0, 1'b0, 1'b1);
      end
      default: begin
        if (int'(ds) < SLOTS) begin
          done_ok = (tbl_owner[ds] != 8'd0) && tbl_busy[ds];
          if (done_ok) tbl_busy[ds] = 1'b0;
          push_reply(KIND_DONE_REPLY, done_ok, ds, tbl_owner[ds], tbl_irq[ds], 1'b1);
        end else begin
          push_reply(KIND_DONE_REPLY, 1'b0, ds, 8'd0, 1'b0, 1'b1);
        end
      end
    endcase
  endtask

  // start stays high after acceptance; the gap task lowers it when needed
  task automatic send_request(req_t r, logic [7:0] id, logic [15:0] ival, logic irq,
                              logic [2:0] ds);
    start        <= 1'b1;
    req_type     <= r;
    task_id      <= id;
    interval     <= ival;
    in_interrupt <= irq;
    done_slot    <= ds;
    do @(posedge clk); while (busy);
    schedule_replies(r, id, ival, irq, ds);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random occupied slot, optionally one waiting for its done; -1 if none
  function automatic int pick_slot(bit want_busy);
    int base;
    int s;
    base = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      s = (base + i) % SLOTS;
      if (tbl_owner[s] != 8'd0 && (!want_busy || tbl_busy[s])) return s;
    end
    return -1;
  endfunction

  function automatic logic [15:0] random_interval();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 16'($urandom_range(0, 6));
    if (roll < 90) return 16'($urandom);
    return roll[0] ? 16'hFFFF : 16'h0000;
  endfunction

  always @(posedge clk) begin : result_check
    reply_t got_r;
    reply_t exp_r;
    if (!rst && result_valid) begin
      got_r.kind = kind_t'(kind);
      got_r.ok   = ok;
      got_r.slot = slot;
      got_r.id   = fired_id;
      got_r.irq  = fired_in_interrupt;
      got_r.last = last;
      if (pending_replies.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < 10)
          $display("%0t: unexpected result kind=%0d ok=%0d slot=%0d id=%0h irq=%0d last=%0d",
                   $realtime, kind, ok, slot, fired_id, fired_in_interrupt, last);
      end else begin
        exp_r = pending_replies.pop_front();
        if (got_r.kind !== exp_r.kind || got_r.ok !== exp_r.ok || got_r.slot !== exp_r.slot ||
            got_r.id !== exp_r.id || got_r.irq !== exp_r.irq || got_r.last !== exp_r.last) begin
          error_count <= error_count + 1;
          if (error_count < 10)
            $display({"%0t: mismatch exp kind=%0d ok=%0d slot=%0d id=%0h irq=%0d last=%0d",
                      " / got kind=%0d ok=%0d slot=%0d id=%0h irq=%0d last=%0d"},
                     $realtime, exp_r.kind, exp_r.ok, exp_r.slot, exp_r.id, exp_r.irq,
                     exp_r.last, kind, ok, slot, fired_id, fired_in_interrupt, last);
        end
      end
    end
  end

  task automatic test_empty_table();
    send_request(REQ_TICK, 8'd0, 16'd0, 1'b0, 3'd0);
    send_request(REQ_DONE, 8'd0, 16'd0, 1'b0, 3'd7);
    send_request(REQ_UNREGISTER, 8'd5, 16'd0, 1'b0, 3'd0);
    send_request(REQ_REGISTER, 8'd0, 16'd3, 1'b1, 3'd0);
  endtask

  task automatic test_register_limits();
    send_request(REQ_REGISTER, 8'hFF, 16'h0000, 1'b0, 3'd0);
    send_request(REQ_REGISTER, 8'h01, 16'hFFFF, 1'b1, 3'd0);
    send_request(REQ_REGISTER, 8'h80, 16'h0001, 1'b0, 3'd0);
    // duplicate id lands in the next free slot
    send_request(REQ_REGISTER, 8'h01, 16'h0002, 1'b1, 3'd0);
    send_request(REQ_REGISTER, 8'hAA, 16'hAAAA, 1'b0, 3'd0);
    send_request(REQ_REGISTER, 8'h55, 16'h5555, 1'b1, 3'd0);
    send_request(REQ_REGISTER, 8'h7F, 16'h0003, 1'b1, 3'd0);
    send_request(REQ_REGISTER, 8'h33, 16'h0000, 1'b1, 3'd0);
    // table full
    send_request(REQ_REGISTER, 8'hFE, 16'h0004, 1'b0, 3'd0);
  endtask

  task automatic test_fire_and_done();
    send_request(REQ_TICK, 8'd0, 16'd0, 1'b0, 3'd0);
    send_request(REQ_TICK, 8'd0, 16'd0, 1'b0, 3'd0);
    send_request(REQ_DONE, 8'd0, 16'd0, 1'b0, 3'd0);
    send_request(REQ_DONE, 8'd0, 16'd0, 1'b0, 3'd1);
    send_request(REQ_TICK, 8'd0, 16'd0, 1'b0, 3'd0);
    send_request(REQ_DONE, 8'd0, 16'd0, 1'b0, 3'd2);
  endtask

  task automatic test_unregister();
    send_request(REQ_UNREGISTER, 8'h01, 16'd0, 1'b0, 3'd0);
    send_request(REQ_UNREGISTER, 8'h00, 16'd0, 1'b0, 3'd0);
    send_request(REQ_UNREGISTER, 8'h01, 16'd0, 1'b0, 3'd0);
    send_request(REQ_UNREGISTER, 8'h42, 16'd0, 1'b0, 3'd0);
  endtask

  task automatic test_random_traffic();
    int          roll;
    int          s;
    logic [7:0]  id;
    logic [2:0]  ds;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        id = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        send_request(REQ_REGISTER, id, random_interval(), 1'($urandom), 3'($urandom));
      end else if (roll < 45) begin
        s = pick_slot(1'b0);
        if (s >= 0 && $urandom_range(0, 3) != 0) id = tbl_owner[s];
        else id = 8'($urandom);
        send_request(REQ_UNREGISTER, id, 16'($urandom), 1'($urandom), 3'($urandom));
      end else if (roll < 80) begin
        send_request(REQ_TICK, 8'($urandom), 16'($urandom), 1'($urandom), 3'($urandom));
      end else begin
        s = pick_slot(1'b1);
        if (s >= 0 && $urandom_range(0, 9) < 7) ds = 3'(s);
        else ds = 3'($urandom);
        send_request(REQ_DONE, 8'($urandom), 16'($urandom), 1'($urandom), ds);
      end
      // let the pipeline run dry now and then
      if (n % 97 == 50) wait_drained();
      else if (n % 64 >= 16) pause_sender(random_gap());
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    req_type     <= REQ_REGISTER;
    task_id      <= 8'd0;
    interval     <= 16'd0;
    in_interrupt <= 1'b0;
    done_slot    <= 3'd0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_owner[i]     = 8'd0;
      tbl_reload[i]    = 16'd0;
      tbl_remaining[i] = 16'd0;
      tbl_irq[i]       = 1'b0;
      tbl_busy[i]      = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_register_limits();
    test_fire_and_done();
    test_unregister();
    wait_drained();
    test_random_traffic();

    wait_drained();
    repeat (SLOTS + 6) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
